@@ sv/nws_pkg.sv @@
// Shared types, widths and constants of the Numerov wavefunction stepper.
`default_nettype none
package nws_pkg;

  // Field widths fixed by the payload structs
  localparam int PSI_WIDTH  = 48;
  localparam int G_WIDTH    = 34;
  localparam int NODE_WIDTH = 16;

  // Fixed-point formats
  localparam int V_WIDTH   = 32;
  localparam int G_FRAC    = 20;
  localparam int COEF_FRAC = 48;

  // Working widths
  localparam int G_EXT_WIDTH = (G_WIDTH + 1 > V_WIDTH + 3) ? G_WIDTH + 1 : V_WIDTH + 3;
  localparam int MUL_WIDTH   = 64;
  localparam int HALF_WIDTH  = MUL_WIDTH / 2;
  localparam int PROD_WIDTH  = 2 * MUL_WIDTH;
  localparam int TERM_WIDTH  = PROD_WIDTH - COEF_FRAC;
  localparam int TERM10_WIDTH = TERM_WIDTH + 4;
  localparam int NUM_WIDTH   = 88;
  localparam int NUM_MAG_WIDTH = 79;
  localparam int DEN_WIDTH   = MUL_WIDTH + 2;
  localparam int OP_WIDTH    = 3;
  localparam int DIV_CNT_WIDTH = 7;

  // Configuration port
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 48;
  localparam int STEP_WIDTH      = 48;
  localparam int START_WIDTH     = 48;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ENERGY_GUESS    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STEP_SQ_OVER_12 = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_START_VALUE     = 2'd2;

  localparam logic [V_WIDTH-1:0]     ENERGY_GUESS_RESET    = 32'd104858;
  localparam logic [STEP_WIDTH-1:0]  STEP_SQ_OVER_12_RESET = 48'd234560;
  localparam logic [START_WIDTH-1:0] START_VALUE_RESET     = 48'd10995116;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Multiply operations of one recurrence step
  localparam logic [OP_WIDTH-1:0] OP_COEF_CUR  = 3'd0;
  localparam logic [OP_WIDTH-1:0] OP_COEF_PREV = 3'd1;
  localparam logic [OP_WIDTH-1:0] OP_COEF_NEW  = 3'd2;
  localparam logic [OP_WIDTH-1:0] OP_TERM_CUR  = 3'd3;
  localparam logic [OP_WIDTH-1:0] OP_TERM_PREV = 3'd4;

  typedef struct packed {
    logic signed [V_WIDTH-1:0] reduced_potential;
    logic                      restart;
  } in_item_t;

  typedef struct packed {
    logic signed [PSI_WIDTH-1:0] psi;
    logic [NODE_WIDTH-1:0]       node_count;
    logic                        saturated;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_RESTART,
    KIND_FIRST,
    KIND_RECUR
  } kind_t;

  typedef struct packed {
    kind_t                       kind;
    logic signed [G_WIDTH-1:0]   g;
    logic                        g_clip;
  } work_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_MUL,
    BS_MUL_POST,
    BS_NUM1,
    BS_NUM2,
    BS_NUM3,
    BS_NUM4,
    BS_DIV,
    BS_ROUND,
    BS_CLAMP,
    BS_FIN
  } back_state_t;

endpackage
`default_nettype wire

@@ sv/nws_front.sv @@
// Front end: takes input transfers, forms G and classifies each grid point.
`default_nettype none
module nws_front
  import nws_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_item_t            in_data,
  input  wire logic [V_WIDTH-1:0]  energy_guess,
  input  wire logic                queue_full,
  output logic                     push,
  output work_t                    push_data
);

  logic [1:0] points_seen;
  logic [1:0] points_seen_next;
  logic signed [G_EXT_WIDTH-1:0] v_ext;
  logic signed [G_EXT_WIDTH-1:0] e_ext;
  logic signed [G_EXT_WIDTH-1:0] d;
  logic [G_EXT_WIDTH-G_WIDTH:0]  d_top;
  logic                          fits;

  // Hold input while the queue is full
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Form G = 2*(v - energy), clip to G width and classify the point
  always_comb begin
    v_ext = signed'({{(G_EXT_WIDTH-V_WIDTH){in_data.reduced_potential[V_WIDTH-1]}},
                     in_data.reduced_potential});
    e_ext = signed'({{(G_EXT_WIDTH-V_WIDTH){energy_guess[V_WIDTH-1]}}, energy_guess});
    d     = (v_ext - e_ext) <<< 1;
    d_top = d[G_EXT_WIDTH-1:G_WIDTH-1];
    fits  = (&d_top) || !(|d_top);
    push_data.g_clip = !fits;
    if (fits) begin
      push_data.g = d[G_WIDTH-1:0];
    end else if (d[G_EXT_WIDTH-1]) begin
      push_data.g = {1'b1, {(G_WIDTH-1){1'b0}}};
    end else begin
      push_data.g = {1'b0, {(G_WIDTH-1){1'b1}}};
    end
    if (in_data.restart || points_seen == 2'd0) begin
      push_data.kind   = KIND_RESTART;
      points_seen_next = 2'd1;
    end else if (points_seen == 2'd1) begin
      push_data.kind   = KIND_FIRST;
      points_seen_next = 2'd2;
    end else begin
      push_data.kind   = KIND_RECUR;
      points_seen_next = 2'd2;
    end
  end

  // Advance run position on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= 2'd0;
    end else if (push) begin
      points_seen <= points_seen_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/nws_queue.sv @@
// Short queue of classified work items between front and back.
`default_nettype none
module nws_queue
  import nws_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire work_t push_data,
  input  wire logic  pop,
  output work_t      head,
  output logic       full,
  output logic       empty
);

  localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_WIDTH = $clog2(DEPTH + 1);
  localparam logic [PTR_WIDTH-1:0] LAST = PTR_WIDTH'(DEPTH - 1);

  work_t                slots [DEPTH];
  logic [PTR_WIDTH-1:0] wr_ptr;
  logic [PTR_WIDTH-1:0] rd_ptr;
  logic [CNT_WIDTH-1:0] count;

  assign full  = (count == CNT_WIDTH'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Store entry
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/nws_back.sv @@
// Back end: Numerov recurrence sequencer with a shared multiplier and a divider.
`default_nettype none
module nws_back
  import nws_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire work_t                  head,
  input  wire logic                   empty,
  output logic                        pop,
  input  wire logic [STEP_WIDTH-1:0]  step_sq_over_12,
  input  wire logic [START_WIDTH-1:0] start_value,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_item_t                   out_data
);

  localparam logic [PROD_WIDTH-1:0] COEF_HALF = PROD_WIDTH'(1) << (G_FRAC - 1);
  localparam logic [PROD_WIDTH-1:0] TERM_HALF = PROD_WIDTH'(1) << (COEF_FRAC - 1);
  localparam logic [MUL_WIDTH-1:0]  COEF_MAX  = {1'b0, {(MUL_WIDTH-1){1'b1}}};
  localparam logic [NUM_MAG_WIDTH-1:0] NUM_MAX = '1;
  localparam logic [PROD_WIDTH-1:0] PSI_POS_LIM = (PROD_WIDTH'(1) << (PSI_WIDTH - 1)) - 1;
  localparam logic [PROD_WIDTH-1:0] PSI_NEG_LIM = PROD_WIDTH'(1) << (PSI_WIDTH - 1);
  localparam logic signed [DEN_WIDTH-1:0] DEN_ONE = DEN_WIDTH'(1) << COEF_FRAC;
  localparam logic [NODE_WIDTH-1:0] NODE_MAX = '1;

  back_state_t state;
  back_state_t state_next;
  logic        load_out;
  logic        out_free;

  // Run state
  logic signed [PSI_WIDTH-1:0] psi_previous;
  logic signed [PSI_WIDTH-1:0] psi_current;
  logic signed [G_WIDTH-1:0]   g_previous;
  logic signed [G_WIDTH-1:0]   g_current;
  logic [NODE_WIDTH-1:0]       nodes_seen;
  logic                        clip_flag;

  // Item in flight
  work_t                       job;
  logic [OP_WIDTH-1:0]         op;
  logic [2:0]                  mul_step;
  logic [1:0]                  pp_shift;
  logic [MUL_WIDTH-1:0]        pp;
  logic [PROD_WIDTH-1:0]       acc;
  logic [MUL_WIDTH-1:0]        c_cur_mag;
  logic [MUL_WIDTH-1:0]        c_prev_mag;
  logic [MUL_WIDTH-1:0]        c_new_mag;
  logic [TERM10_WIDTH-1:0]     term_cur10;
  logic [TERM_WIDTH-1:0]       term_prev;
  logic signed [NUM_WIDTH-1:0] num;
  logic [MUL_WIDTH-1:0]        dm;
  logic                        dneg;
  logic [PROD_WIDTH-1:0]       dividend;
  logic [MUL_WIDTH-1:0]        rem;
  logic [PROD_WIDTH-1:0]       quo;
  logic                        qneg;
  logic [DIV_CNT_WIDTH-1:0]    div_cnt;
  logic signed [PSI_WIDTH-1:0] psi_res;

  // Combinational helpers
  logic [G_WIDTH-1:0]          g_cur_mag;
  logic [G_WIDTH-1:0]          g_prev_mag;
  logic [G_WIDTH-1:0]          g_new_mag;
  logic [PSI_WIDTH-1:0]        psi_cur_mag;
  logic [PSI_WIDTH-1:0]        psi_prev_mag;
  logic [MUL_WIDTH-1:0]        op_a;
  logic [MUL_WIDTH-1:0]        op_b;
  logic [HALF_WIDTH-1:0]       a_half;
  logic [HALF_WIDTH-1:0]       b_half;
  logic [MUL_WIDTH-1:0]        pp_next;
  logic [PROD_WIDTH-1:0]       pp_aligned;
  logic [TERM_WIDTH-1:0]       term;
  logic signed [DEN_WIDTH-1:0] den;
  logic [NUM_WIDTH-1:0]        num_mag;
  logic [MUL_WIDTH:0]          rem_shift;
  logic                        rem_ge;
  logic [PROD_WIDTH-1:0]       psi_lim;
  logic                        psi_over;
  logic [PROD_WIDTH-1:0]       psi_mag;
  logic signed [PSI_WIDTH-1:0] psi_clamped;
  logic                        is_node;
  logic [NODE_WIDTH-1:0]       nodes_next;
  logic [START_WIDTH-1:0]      start_mag;

  assign out_free = !out_valid || !out_stall;

  // Magnitudes of stored values
  always_comb begin
    g_cur_mag    = g_current[G_WIDTH-1] ? G_WIDTH'(-g_current) : G_WIDTH'(g_current);
    g_prev_mag   = g_previous[G_WIDTH-1] ? G_WIDTH'(-g_previous) : G_WIDTH'(g_previous);
    g_new_mag    = job.g[G_WIDTH-1] ? G_WIDTH'(-job.g) : G_WIDTH'(job.g);
    psi_cur_mag  = psi_current[PSI_WIDTH-1] ? PSI_WIDTH'(-psi_current)
                                            : PSI_WIDTH'(psi_current);
    psi_prev_mag = psi_previous[PSI_WIDTH-1] ? PSI_WIDTH'(-psi_previous)
                                             : PSI_WIDTH'(psi_previous);
    start_mag    = start_value[START_WIDTH-1] ? START_WIDTH'(-start_value) : start_value;
  end

  // Select multiplier operands and partial product
  always_comb begin
    case (op)
      OP_COEF_CUR: begin
        op_a = MUL_WIDTH'(step_sq_over_12);
        op_b = MUL_WIDTH'(g_cur_mag);
      end
      OP_COEF_PREV: begin
        op_a = MUL_WIDTH'(step_sq_over_12);
        op_b = MUL_WIDTH'(g_prev_mag);
      end
      OP_COEF_NEW: begin
        op_a = MUL_WIDTH'(step_sq_over_12);
        op_b = MUL_WIDTH'(g_new_mag);
      end
      OP_TERM_CUR: begin
        op_a = c_cur_mag;
        op_b = MUL_WIDTH'(psi_cur_mag);
      end
      OP_TERM_PREV: begin
        op_a = c_prev_mag;
        op_b = MUL_WIDTH'(psi_prev_mag);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    a_half  = mul_step[0] ? op_a[MUL_WIDTH-1:HALF_WIDTH] : op_a[HALF_WIDTH-1:0];
    b_half  = mul_step[1] ? op_b[MUL_WIDTH-1:HALF_WIDTH] : op_b[HALF_WIDTH-1:0];
    pp_next = a_half * b_half;
    case (pp_shift)
      2'd0:    pp_aligned = PROD_WIDTH'(pp);
      2'd1:    pp_aligned = PROD_WIDTH'(pp) << HALF_WIDTH;
      2'd2:    pp_aligned = PROD_WIDTH'(pp) << MUL_WIDTH;
      default: pp_aligned = '0;
    endcase
    term = acc[PROD_WIDTH-1:COEF_FRAC];
  end

  // Divisor, numerator magnitude and divide step
  always_comb begin
    if (job.g[G_WIDTH-1]) begin
      den = DEN_ONE + signed'(DEN_WIDTH'(c_new_mag));
    end else begin
      den = DEN_ONE - signed'(DEN_WIDTH'(c_new_mag));
    end
    num_mag   = num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
    rem_shift = {rem, dividend[PROD_WIDTH-1]};
    rem_ge    = rem_shift >= {1'b0, dm};
  end

  // Clamp quotient to psi range and count nodes
  always_comb begin
    psi_lim     = qneg ? PSI_NEG_LIM : PSI_POS_LIM;
    psi_over    = quo > psi_lim;
    psi_mag     = psi_over ? psi_lim : quo;
    psi_clamped = qneg ? PSI_WIDTH'(-psi_mag[PSI_WIDTH-1:0]) : PSI_WIDTH'(psi_mag);
    is_node     = (psi_res[PSI_WIDTH-1] && !psi_current[PSI_WIDTH-1] && psi_current != '0)
               || (!psi_res[PSI_WIDTH-1] && psi_res != '0 && psi_current[PSI_WIDTH-1]);
    if (job.kind == KIND_RESTART) begin
      nodes_next = '0;
    end else if (is_node && nodes_seen != NODE_MAX) begin
      nodes_next = nodes_seen + 1'b1;
    end else begin
      nodes_next = nodes_seen;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BS_IDLE: begin
        if (!empty) begin
          case (head.kind)
            KIND_RESTART: state_next = BS_FIN;
            KIND_FIRST:   state_next = BS_CLAMP;
            default:      state_next = BS_MUL;
          endcase
        end
      end
      BS_MUL:      if (mul_step == 3'd4) state_next = BS_MUL_POST;
      BS_MUL_POST: state_next = (op == OP_TERM_PREV) ? BS_NUM1 : BS_MUL;
      BS_NUM1:     state_next = BS_NUM2;
      BS_NUM2:     state_next = BS_NUM3;
      BS_NUM3:     state_next = BS_NUM4;
      BS_NUM4:     state_next = (dm == '0) ? BS_CLAMP : BS_DIV;
      BS_DIV:      if (div_cnt == '1) state_next = BS_ROUND;
      BS_ROUND:    state_next = BS_CLAMP;
      BS_CLAMP:    state_next = BS_FIN;
      BS_FIN:      if (out_free) state_next = BS_IDLE;
      default:     state_next = BS_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop      = (state == BS_IDLE) && !empty;
    load_out = (state == BS_FIN) && out_free;
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      BS_IDLE: begin
        job      <= head;
        op       <= OP_COEF_CUR;
        mul_step <= '0;
        psi_res  <= '0;
        qneg     <= start_value[START_WIDTH-1];
        quo      <= PROD_WIDTH'(start_mag);
      end
      BS_MUL: begin
        if (mul_step != 3'd4) begin
          pp       <= pp_next;
          pp_shift <= 2'(mul_step[0]) + 2'(mul_step[1]);
        end
        if (mul_step == 3'd0) begin
          acc <= (op < OP_TERM_CUR) ? COEF_HALF : TERM_HALF;
        end else begin
          acc <= acc + pp_aligned;
        end
        mul_step <= mul_step + 1'b1;
      end
      BS_MUL_POST: begin
        case (op)
          OP_COEF_CUR:  c_cur_mag  <= (acc[PROD_WIDTH-1:G_FRAC+MUL_WIDTH-1] != '0)
                                      ? COEF_MAX : acc[G_FRAC+MUL_WIDTH-1:G_FRAC];
          OP_COEF_PREV: c_prev_mag <= (acc[PROD_WIDTH-1:G_FRAC+MUL_WIDTH-1] != '0)
                                      ? COEF_MAX : acc[G_FRAC+MUL_WIDTH-1:G_FRAC];
          OP_COEF_NEW:  c_new_mag  <= (acc[PROD_WIDTH-1:G_FRAC+MUL_WIDTH-1] != '0)
                                      ? COEF_MAX : acc[G_FRAC+MUL_WIDTH-1:G_FRAC];
          OP_TERM_CUR:  term_cur10 <= (TERM10_WIDTH'(term) << 3) + (TERM10_WIDTH'(term) << 1);
          OP_TERM_PREV: term_prev  <= term;
          default: ;
        endcase
        op       <= op + 1'b1;
        mul_step <= '0;
      end
      BS_NUM1: begin
        num  <= (NUM_WIDTH'(psi_current) <<< 1) - NUM_WIDTH'(psi_previous);
        dneg <= den[DEN_WIDTH-1];
        dm   <= den[DEN_WIDTH-1] ? MUL_WIDTH'(-den) : MUL_WIDTH'(den);
      end
      BS_NUM2: begin
        if (g_current[G_WIDTH-1] ^ psi_current[PSI_WIDTH-1]) begin
          num <= num - signed'(NUM_WIDTH'(term_cur10));
        end else begin
          num <= num + signed'(NUM_WIDTH'(term_cur10));
        end
      end
      BS_NUM3: begin
        if (g_previous[G_WIDTH-1] ^ psi_previous[PSI_WIDTH-1]) begin
          num <= num - signed'(NUM_WIDTH'(term_prev));
        end else begin
          num <= num + signed'(NUM_WIDTH'(term_prev));
        end
      end
      BS_NUM4: begin
        qneg    <= num[NUM_WIDTH-1] ^ dneg;
        rem     <= '0;
        div_cnt <= '0;
        if (num_mag[NUM_WIDTH-1:NUM_MAG_WIDTH] != '0) begin
          dividend <= {1'b0, NUM_MAX, {COEF_FRAC{1'b0}}};
        end else begin
          dividend <= {1'b0, num_mag[NUM_MAG_WIDTH-1:0], {COEF_FRAC{1'b0}}};
        end
        if (dm == '0) begin
          quo <= (num_mag == '0) ? '0 : (PROD_WIDTH'(1) << MUL_WIDTH);
        end else begin
          quo <= '0;
        end
      end
      BS_DIV: begin
        dividend <= dividend << 1;
        div_cnt  <= div_cnt + 1'b1;
        if (rem_ge) begin
          rem <= MUL_WIDTH'(rem_shift - {1'b0, dm});
          quo <= {quo[PROD_WIDTH-2:0], 1'b1};
        end else begin
          rem <= rem_shift[MUL_WIDTH-1:0];
          quo <= {quo[PROD_WIDTH-2:0], 1'b0};
        end
      end
      BS_ROUND: begin
        if ({rem, 1'b0} >= {1'b0, dm}) begin
          quo <= quo + 1'b1;
        end
      end
      BS_CLAMP: begin
        psi_res <= psi_clamped;
      end
      default: ;
    endcase
  end

  // Run state and sticky flag
  always_ff @(posedge clk) begin
    if (rst) begin
      psi_previous <= '0;
      psi_current  <= '0;
      g_previous   <= '0;
      g_current    <= '0;
      nodes_seen   <= '0;
      clip_flag    <= 1'b0;
    end else begin
      if (pop) begin
        clip_flag <= (head.kind == KIND_RESTART) ? head.g_clip : (clip_flag | head.g_clip);
      end
      if (state == BS_MUL_POST && op < OP_TERM_CUR
          && acc[PROD_WIDTH-1:G_FRAC+MUL_WIDTH-1] != '0) begin
        clip_flag <= 1'b1;
      end
      if (state == BS_NUM4 && (num_mag[NUM_WIDTH-1:NUM_MAG_WIDTH] != '0 || dm == '0)) begin
        clip_flag <= 1'b1;
      end
      if (state == BS_CLAMP && psi_over) begin
        clip_flag <= 1'b1;
      end
      if (load_out) begin
        nodes_seen <= nodes_next;
        if (job.kind == KIND_RESTART) begin
          psi_previous <= '0;
          psi_current  <= '0;
          g_previous   <= '0;
        end else begin
          psi_previous <= psi_current;
          psi_current  <= psi_res;
          g_previous   <= g_current;
        end
        g_current <= job.g;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.psi        <= psi_res;
      out_data.node_count <= nodes_next;
      out_data.saturated  <= clip_flag;
    end
  end

endmodule
`default_nettype wire

@@ sv/numerov_wavefunction_stepper.sv @@
// Top level: configuration registers, front end, work queue and back end.
// The back end handles one point at a time; a recurrence point runs through five
// 4-pass 32x32 multiplies and a 128-step restoring divide in the back end.
// Reset (rst, synchronous): run state, queue and output cleared, registers to defaults.
`default_nettype none
module numerov_wavefunction_stepper
  import nws_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire in_item_t                   in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output out_item_t                       out_data,
  input  wire logic                       cfg_write,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  logic [V_WIDTH-1:0]     energy_guess;
  logic [STEP_WIDTH-1:0]  step_sq_over_12;
  logic [START_WIDTH-1:0] start_value;

  logic  push;
  work_t push_data;
  logic  pop;
  work_t head;
  logic  full;
  logic  empty;

  // Configuration registers; writes to unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_guess    <= ENERGY_GUESS_RESET;
      step_sq_over_12 <= STEP_SQ_OVER_12_RESET;
      start_value     <= START_VALUE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ENERGY_GUESS:    energy_guess    <= cfg_data[V_WIDTH-1:0];
        CFG_STEP_SQ_OVER_12: step_sq_over_12 <= cfg_data[STEP_WIDTH-1:0];
        CFG_START_VALUE:     start_value     <= cfg_data[START_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  nws_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .energy_guess (energy_guess),
    .queue_full   (full),
    .push         (push),
    .push_data    (push_data)
  );

  nws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  nws_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .empty           (empty),
    .pop             (pop),
    .step_sq_over_12 (step_sq_over_12),
    .start_value     (start_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data)
  );

endmodule
`default_nettype wire
